@@ hw/rtl/nhe_pkg.sv @@
// Shared types and codes for the net wirelength evaluator.
// Item structs, command codes and controller states; no dependencies.
`default_nettype none

package nhe_pkg;

  localparam int WL_W  = 33;
  localparam int CNT_W = 13;
  localparam int NET_W = 10;
  localparam int PIN_W = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLOSE  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [PIN_W-1:0] pin_x;
    logic signed [PIN_W-1:0] pin_y;
    logic [NET_W-1:0]        net_index;
    logic signed [PIN_W-1:0] slot_x;
    logic signed [PIN_W-1:0] slot_y;
  } in_item_t;

  typedef struct packed {
    logic [WL_W-1:0]  wirelength;
    logic [CNT_W-1:0] sink_count;
    logic             error;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_QLO  = 6'b000010,
    ST_QHI  = 6'b000100,
    ST_WALK = 6'b001000,
    ST_CALC = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/nhe_bbox.sv @@
// Bounding box accumulator: min/max registers per axis, spans out.
// Uses no package.
`default_nettype none

module nhe_bbox #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         init,
  input  logic signed [COORD_BITS-1:0] slot_x,
  input  logic signed [COORD_BITS-1:0] slot_y,
  input  logic                         upd,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  output logic [COORD_BITS-1:0]        span_x,
  output logic [COORD_BITS-1:0]        span_y
);

  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;

  always_ff @(posedge clk) begin
    if (init) begin
      lo_x <= slot_x;
      hi_x <= slot_x;
      lo_y <= slot_y;
      hi_y <= slot_y;
    end else if (upd) begin
      if (pt_x < lo_x) lo_x <= pt_x;
      if (pt_x > hi_x) hi_x <= pt_x;
      if (pt_y < lo_y) lo_y <= pt_y;
      if (pt_y > hi_y) hi_y <= pt_y;
    end
  end

  // hi >= lo, so the difference always fits unsigned in COORD_BITS
  assign span_x = COORD_BITS'(hi_x - lo_x);
  assign span_y = COORD_BITS'(hi_y - lo_y);

endmodule

`default_nettype wire

@@ hw/rtl/net_hpwl_evaluator_unit.sv @@
// Top level of the net half-perimeter wirelength evaluator.
// Depends on nhe_pkg and nhe_bbox.
//
// Nets are appended sink by sink into a packed coordinate memory and closed into
// an offset table; a query returns bounding box width plus height around a slot.
// Append, close, refused commands and unused codes load the result register as
// they are accepted. A query holds off the input while it works through its steps:
// acceptance, two reads of the offset table (start and end of the net) through its
// single read port, one read of the sink memory per sink, a drain of the last read,
// a check that sees the walk finished, a span step and a result step. Only one item
// is in work at a time; a new item is taken only while the output register is empty
// or being read in the same cycle, so a waiting result holds off the input.
// No clearing pass is needed after reset: only written entries are ever used.
`default_nettype none

module net_hpwl_evaluator_unit #(
  parameter int MAX_SINKS  = 4096,
  parameter int MAX_NETS   = 1024,
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nhe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nhe_pkg::out_item_t out_data
);

  import nhe_pkg::*;

  localparam int SAW = $clog2(MAX_SINKS);
  localparam int SCW = $clog2(MAX_SINKS + 1);
  localparam int NCW = $clog2(MAX_NETS + 1);
  localparam int CB  = COORD_BITS;

  logic [2*CB-1:0]  sink_mem [MAX_SINKS];
  logic [SCW-1:0]   tab_mem  [MAX_NETS + 1];

  state_t           state;
  logic [SCW-1:0]   sinks_stored;
  logic [NCW-1:0]   nets_closed;
  logic [NCW-1:0]   qnet;
  logic [SCW-1:0]   lo_ptr, hi_ptr, ptr;
  logic             rd_pend;
  logic [CB-1:0]    dx, dy;
  logic [SCW-1:0]   cnt;
  logic [SCW-1:0]   tab_q;
  logic [2*CB-1:0]  sink_q;

  logic             in_acc, slot_free, out_load;
  logic             app_err, close_err, q_err, imm_err;
  logic             tab_we, sink_we, walk_issue, bbox_init;
  logic [NCW-1:0]   tab_ra, tab_wa;
  logic [CB-1:0]    span_x, span_y;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;

  assign app_err   = (sinks_stored == SCW'(MAX_SINKS));
  assign close_err = (nets_closed == NCW'(MAX_NETS));
  assign q_err     = (32'(in_data.net_index) >= 32'(nets_closed));

  always_comb begin
    unique case (in_data.cmd)
      CMD_APPEND: imm_err = app_err;
      CMD_CLOSE:  imm_err = close_err;
      CMD_QUERY:  imm_err = q_err;
      default:    imm_err = 1'b0;
    endcase
  end

  assign sink_we   = in_acc && (in_data.cmd == CMD_APPEND) && !app_err;
  assign tab_we    = in_acc && (in_data.cmd == CMD_CLOSE) && !close_err;
  assign tab_wa    = nets_closed + 1'b1;
  // first read fetches the net's start, second its end
  assign tab_ra    = (state == ST_QLO) ? qnet + 1'b1 : NCW'(in_data.net_index);
  assign walk_issue = (state == ST_WALK) && (ptr < hi_ptr);
  assign bbox_init = in_acc && (in_data.cmd == CMD_QUERY);

  // result register loads when a non-query item or a refused query is accepted, or at the end of a query
  assign out_load  = (in_acc && !((in_data.cmd == CMD_QUERY) && !q_err)) ||
                     ((state == ST_DONE) && slot_free);

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= sinks_stored;
    tab_q <= tab_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (sink_we) begin
      sink_mem[sinks_stored[SAW-1:0]] <= {in_data.pin_x[CB-1:0], in_data.pin_y[CB-1:0]};
    end
    sink_q <= sink_mem[ptr[SAW-1:0]];
  end

  nhe_bbox #(.COORD_BITS(CB)) u_bbox (
    .clk    (clk),
    .init   (bbox_init),
    .slot_x (in_data.slot_x[CB-1:0]),
    .slot_y (in_data.slot_y[CB-1:0]),
    .upd    (rd_pend),
    .pt_x   (sink_q[2*CB-1:CB]),
    .pt_y   (sink_q[CB-1:0]),
    .span_x (span_x),
    .span_y (span_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sinks_stored <= '0;
      nets_closed  <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (sink_we) sinks_stored <= sinks_stored + 1'b1;
            if (tab_we) nets_closed <= nets_closed + 1'b1;
            if ((in_data.cmd == CMD_QUERY) && !q_err) begin
              qnet  <= NCW'(in_data.net_index);
              state <= ST_QLO;
            end else begin
              out_data.wirelength <= '0;
              out_data.sink_count <= '0;
              out_data.error      <= imm_err;
            end
          end
        end
        ST_QLO: begin
          // entry 0 of the offset table is never written; a start of zero is used instead
          lo_ptr <= (qnet == '0) ? '0 : tab_q;
          state  <= ST_QHI;
        end
        ST_QHI: begin
          hi_ptr <= tab_q;
          ptr    <= lo_ptr;
          state  <= ST_WALK;
        end
        ST_WALK: begin
          rd_pend <= walk_issue;
          if (walk_issue) ptr <= ptr + 1'b1;
          if (!walk_issue && !rd_pend) state <= ST_CALC;
        end
        ST_CALC: begin
          dx    <= span_x;
          dy    <= span_y;
          cnt   <= hi_ptr - lo_ptr;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_data.wirelength <= WL_W'({1'b0, dx} + {1'b0, dy});
            out_data.sink_count <= CNT_W'(cnt);
            out_data.error      <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nhe_checker.sv @@
// Port-level checks for the net wirelength evaluator, bound to the top level.
// Depends on nhe_pkg.
`default_nettype none

module nhe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input nhe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nhe_pkg::out_item_t out_data
);

  import nhe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.wirelength == '0 && out_data.sink_count == '0)
    else $error("refused command carries nonzero result");

  a_empty_net: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sink_count == '0 |-> out_data.wirelength == '0)
    else $error("net without sinks gave nonzero wirelength");

  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd != CMD_QUERY |=>
      out_valid && out_data.wirelength == '0 && out_data.sink_count == '0)
    else $error("append or close result missing on next cycle");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind net_hpwl_evaluator_unit nhe_checker u_nhe_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for net_hpwl_evaluator_unit: append, close and query items
// go through a bursty driver and a stalling receiver, checked against a local model.
// Depends on nhe_pkg and the evaluator RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nhe_pkg::*;

  localparam int N_SINKS   = 4096;
  localparam int N_NETS    = 1024;
  localparam int RAND_ITEMS = 900;
  localparam int LIMIT     = 400_000;
  localparam int HOLD_A    = 2000;
  localparam int HOLD_B    = 8000;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN     = 32;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  net_hpwl_evaluator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Model state of the net store
  logic signed [31:0] sink_x [N_SINKS];
  logic signed [31:0] sink_y [N_SINKS];
  int unsigned        net_base [N_NETS+1];
  int unsigned        sink_cnt;
  int unsigned        net_cnt;

  in_item_t  stim_q[$];
  out_item_t hpwl_expect_q[$];
  int        fail_cnt;
  int        cycle_cnt;

  // Generator-side view of the net table, used to pick net indexes
  int unsigned gen_nets;

  logic item_taken;
  int   burst_left;
  int   gap_left;
  int   rdy_cyc;
  int   rdy_mode;
  int   mode_left;

  function automatic out_item_t hpwl_predict(in_item_t it);
    out_item_t   r;
    int unsigned n;
    int unsigned first;
    int unsigned stop;
    longint      lox, hix, loy, hiy, px, py;
    r = '0;
    case (it.cmd)
      CMD_APPEND: begin
        if (sink_cnt >= N_SINKS) begin
          r.error = 1'b1;
        end else begin
          sink_x[sink_cnt] = $signed(it.pin_x);
          sink_y[sink_cnt] = $signed(it.pin_y);
          sink_cnt++;
        end
      end
      CMD_CLOSE: begin
        if (net_cnt >= N_NETS) begin
          r.error = 1'b1;
        end else begin
          net_cnt++;
          net_base[net_cnt] = sink_cnt;
        end
      end
      CMD_QUERY: begin
        n = 32'(it.net_index);
        if (n >= net_cnt) begin
          r.error = 1'b1;
        end else begin
          first = net_base[n];
          stop  = net_base[n+1];
          lox = $signed(it.slot_x);
          hix = lox;
          loy = $signed(it.slot_y);
          hiy = loy;
          for (int unsigned i = first; i < stop; i++) begin
            px = sink_x[i];
            py = sink_y[i];
            if (px < lox) lox = px;
            if (px > hix) hix = px;
            if (py < loy) loy = py;
            if (py > hiy) hiy = py;
          end
          r.wirelength = WL_W'((hix - lox) + (hiy - loy));
          r.sink_count = CNT_W'(stop - first);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // All fields random; each push task then sets the ones its command uses
  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd       = 2'($urandom_range(0, 3));
    it.pin_x     = $urandom;
    it.pin_y     = $urandom;
    it.net_index = NET_W'($urandom);
    it.slot_x    = $urandom;
    it.slot_y    = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord(logic [31:0] center);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2:    v = $urandom;
      default: v = center + $urandom_range(0, 4000) - 32'd2000;
    endcase
    return v;
  endfunction

  task automatic stim_add(in_item_t it);
    stim_q = {stim_q, it};
  endtask

  task automatic push_append(logic [31:0] x, logic [31:0] y);
    in_item_t it;
    it = noise_item();
    it.cmd   = CMD_APPEND;
    it.pin_x = x;
    it.pin_y = y;
    stim_add(it);
  endtask

  task automatic push_close();
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_CLOSE;
    stim_add(it);
    if (gen_nets < N_NETS) gen_nets++;
  endtask

  task automatic push_query(int unsigned idx, logic [31:0] x, logic [31:0] y);
    in_item_t it;
    it = noise_item();
    it.cmd       = CMD_QUERY;
    it.net_index = NET_W'(idx);
    it.slot_x    = x;
    it.slot_y    = y;
    stim_add(it);
  endtask

  task automatic push_unused();
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_UNUSED;
    stim_add(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Input side: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Output side: changing stall patterns plus two long hold-offs
  always @(negedge clk) begin
    rdy_cyc = rdy_cyc + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if ((rdy_cyc >= HOLD_A && rdy_cyc < HOLD_A + HOLD_LEN) ||
                 (rdy_cyc >= HOLD_B && rdy_cyc < HOLD_B + HOLD_LEN)) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (rdy_cyc % 3 == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Acceptance on both channels; prediction in acceptance order
  always @(posedge clk) begin
    out_item_t want;
    item_taken = !rst && in_valid && in_ready;
    if (item_taken) hpwl_expect_q = {hpwl_expect_q, hpwl_predict(in_data)};
    if (!rst && out_valid && out_ready) begin
      if (hpwl_expect_q.size() == 0) begin
        $error("result item with no expectation: wirelength %0d sink_count %0d error %0b",
               out_data.wirelength, out_data.sink_count, out_data.error);
        fail_cnt++;
      end else begin
        want = hpwl_expect_q.pop_front();
        if (out_data.wirelength !== want.wirelength) begin
          $error("wirelength: expected %0d, actual %0d", want.wirelength, out_data.wirelength);
          fail_cnt++;
        end
        if (out_data.sink_count !== want.sink_count) begin
          $error("sink_count: expected %0d, actual %0d", want.sink_count, out_data.sink_count);
          fail_cnt++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %0b, actual %0b", want.error, out_data.error);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int          rand_items;
    int          k;
    int          sel;
    logic [31:0] center;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    item_taken = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    rdy_cyc    = 0;
    rdy_mode   = 0;
    mode_left  = 0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    sink_cnt   = 0;
    net_cnt    = 0;
    net_base[0] = 0;
    gen_nets   = 0;
    rand_items = 0;

    // Directed: unclosed and empty nets, extreme coordinates, unused code
    push_query(0, 32'd0, 32'd0);
    push_close();
    push_query(0, 32'h8000_0000, 32'h7fff_ffff);
    push_unused();
    push_append(32'h8000_0000, 32'h7fff_ffff);
    push_append(32'h7fff_ffff, 32'h8000_0000);
    push_append(32'h0000_0000, 32'h0000_0000);
    push_append(32'hffff_ffff, 32'hffff_ffff);
    push_close();
    push_query(1, 32'd0, 32'd0);
    push_query(1, 32'h8000_0000, 32'h7fff_ffff);
    push_append(32'd5, -32'sd7);
    push_close();
    push_query(2, 32'd5, -32'sd7);
    push_query(2, 32'h7fff_ffff, 32'h8000_0000);
    push_query(3, 32'd0, 32'd0);
    push_query(N_NETS - 1, 32'd0, 32'd0);
    push_append(32'hffff_ffff, 32'h0000_0001);
    push_append(32'h0000_0001, 32'hffff_ffff);
    push_close();
    push_query(3, 32'hffff_ffff, 32'hffff_ffff);
    push_query(0, 32'h7fff_ffff, 32'h7fff_ffff);
    push_unused();

    // Random: mostly whole nets and queries of closed ones, some noise
    center = $urandom;
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        center = $urandom;
        k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (k) push_append(rand_coord(center), rand_coord(center));
        push_close();
        rand_items += k + 1;
      end else if (sel < 90) begin
        k = $urandom_range(1, 4);
        repeat (k) push_query($urandom_range(0, gen_nets - 1), rand_coord(center),
                              rand_coord(center));
        rand_items += k;
      end else begin
        case ($urandom_range(0, 2))
          0:       push_unused();
          1:       push_query($urandom_range(gen_nets, N_NETS - 1), $urandom, $urandom);
          default: push_append(rand_coord(center), rand_coord(center));
        endcase
        rand_items++;
      end
    end

    // Fill the net table and hit the full case
    repeat (3) push_append($urandom, $urandom);
    while (gen_nets < N_NETS) push_close();
    repeat (3) push_close();
    repeat (30) push_query($urandom_range(0, N_NETS - 1), $urandom, $urandom);
    push_query(N_NETS - 1, $urandom, $urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid || hpwl_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_cnt == 0 && hpwl_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
